// ===== hdl/dmpt_pkg.sv =====
// Shared types and constants for the direct-mapped position table.
// Holds the transaction and slot layouts, the operation codes and the counter limits.
// No dependencies.
`timescale 1ns / 1ps

package dmpt_pkg;

  // Default table depth.
  localparam int unsigned ENTRIES_DEFAULT = 4096;

  // Field widths fixed by the interface.
  localparam int unsigned KEY_W   = 64;
  localparam int unsigned CNT_W   = 32;
  localparam int unsigned USED_W  = 13;

  // Depth of the queue between the front and the back.
  localparam int unsigned QUEUE_DEPTH = 2;

  // Operation codes.
  localparam logic [1:0] FUNC_LOOKUP = 2'd0;
  localparam logic [1:0] FUNC_STORE  = 2'd1;
  localparam logic [1:0] FUNC_CLEAR  = 2'd2;

  // Saturation limits of the counters.
  localparam logic [CNT_W-1:0]  CNT_MAX  = '1;
  localparam logic [USED_W-1:0] USED_MAX = '1;

  // One accepted transaction, as it leaves the input ports.
  typedef struct packed {
    logic [1:0]        func;
    logic [KEY_W-1:0]  key;
    logic [1:0]        node_type;
    logic signed [15:0] score;
    logic [7:0]        search_depth;
    logic [15:0]       best_move;
  } item_t;

  // One slot of the table. A node type of zero marks the slot as empty.
  typedef struct packed {
    logic [1:0]        node_type;
    logic [KEY_W-1:0]  key;
    logic signed [15:0] score;
    logic [7:0]        search_depth;
    logic [15:0]       best_move;
  } entry_t;

  // Result of one transaction as seen by the receiver.
  typedef struct packed {
    logic              hit;
    logic [1:0]        found_type;
    logic signed [15:0] found_score;
    logic [7:0]        found_depth;
    logic [15:0]       found_move;
  } found_t;

endpackage

// ===== hdl/dmpt_front.sv =====
// Front stage of the position table: takes a transaction and works out its slot index.
// Power-of-two depths use the low key bits; other depths fold the key bytes and reduce them.
// Depends on dmpt_pkg.
`timescale 1ns / 1ps

module dmpt_front #(
  parameter int unsigned ENTRIES = dmpt_pkg::ENTRIES_DEFAULT
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  dmpt_pkg::item_t            in_item,
  output logic                       busy,
  input  logic                       q_full,
  output logic                       q_push,
  output logic [$clog2(ENTRIES)-1:0] q_idx,
  output dmpt_pkg::item_t            q_item
);

  // Weight of each key byte: 256 to the power of the byte position, modulo ENTRIES.
  function automatic logic [255:0] byte_weights();
    logic [255:0]    w;
    longint unsigned p;
    w = '0;
    p = 64'(1 % ENTRIES);
    for (int j = 0; j < 8; j++) begin
      w[j*32 +: 32] = 32'(p);
      p = (p * 64'd256) % 64'(ENTRIES);
    end
    return w;
  endfunction

  localparam int unsigned IDX_W     = $clog2(ENTRIES);
  localparam bit          POW2      = ((ENTRIES & (ENTRIES - 1)) == 0);
  // Eight byte folds, a quotient estimate, a subtract and one correction.
  localparam int unsigned NP_CYCLES = 11;
  localparam int unsigned CNT_BW    = $clog2(NP_CYCLES + 1);
  localparam logic [31:0] ENT_W32   = 32'(ENTRIES);
  localparam logic [31:0] RECIP     = 32'((64'd1 << 32) / ENTRIES);
  localparam logic [255:0] WEIGHTS  = byte_weights();

  logic                       occ;
  dmpt_pkg::item_t            item;
  logic [dmpt_pkg::KEY_W-1:0] key_sh;
  logic [CNT_BW-1:0]          cnt;
  logic [2:0]                 wsel;
  logic [31:0]                weight;
  logic [31:0]                acc;
  logic [31:0]                quo;
  logic [31:0]                part;
  logic [63:0]                prod;
  logic [IDX_W-1:0]           rem;

  // Byte weight for the current fold and the reciprocal product of the folded sum.
  assign wsel   = 3'(CNT_BW'(NP_CYCLES) - cnt);
  assign weight = WEIGHTS[32*wsel +: 32];
  assign prod   = {32'd0, acc} * {32'd0, RECIP};

  assign busy   = occ;
  assign q_push = occ && (cnt == '0) && !q_full;
  assign q_idx  = POW2 ? item.key[IDX_W-1:0] : rem;
  assign q_item = item;

  // Control: the stage holds one transaction until its index is known and the queue has room.
  always_ff @(posedge clk) begin
    if (rst) begin
      occ <= 1'b0;
      cnt <= '0;
    end else begin
      if (start && !occ) begin
        occ <= 1'b1;
        cnt <= POW2 ? '0 : CNT_BW'(NP_CYCLES);
      end else if (q_push) begin
        occ <= 1'b0;
      end else if (occ && (cnt != '0)) begin
        cnt <= cnt - 1'b1;
      end
    end
  end

  // Payload and remainder datapath. The folded sum stays below 2^31, so the
  // reciprocal estimate of the quotient is at most one low and one correction suffices.
  always_ff @(posedge clk) begin
    if (start && !occ) begin
      item   <= in_item;
      key_sh <= in_item.key;
      acc    <= '0;
    end else if (occ && (cnt > CNT_BW'(3))) begin
      acc    <= acc + 32'(key_sh[7:0]) * weight;
      key_sh <= key_sh >> 8;
    end else if (occ && (cnt == CNT_BW'(3))) begin
      quo <= prod[63:32];
    end else if (occ && (cnt == CNT_BW'(2))) begin
      part <= acc - quo * ENT_W32;
    end else if (occ && (cnt == CNT_BW'(1))) begin
      rem <= (part >= ENT_W32) ? IDX_W'(part - ENT_W32) : IDX_W'(part);
    end
  end

endmodule

// ===== hdl/dmpt_queue.sv =====
// Short first-in first-out queue that decouples the front from the back.
// Carries the slot index together with the transaction.
// Depends on dmpt_pkg.
`timescale 1ns / 1ps

module dmpt_queue #(
  parameter int unsigned IDX_W = 12
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  input  logic [IDX_W-1:0]     push_idx,
  input  dmpt_pkg::item_t      push_item,
  output logic                 full,
  input  logic                 pop,
  output logic                 valid,
  output logic [IDX_W-1:0]     head_idx,
  output dmpt_pkg::item_t      head_item
);

  localparam int unsigned DEPTH = dmpt_pkg::QUEUE_DEPTH;
  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  logic [IDX_W-1:0]  idx_q  [DEPTH];
  dmpt_pkg::item_t   item_q [DEPTH];
  logic [PTR_W-1:0]  wr_ptr;
  logic [PTR_W-1:0]  rd_ptr;
  logic [CNT_W-1:0]  count;
  logic              do_push;
  logic              do_pop;

  assign full      = (count == CNT_W'(DEPTH));
  assign valid     = (count != '0);
  assign do_push   = push && !full;
  assign do_pop    = pop && valid;
  assign head_idx  = idx_q[rd_ptr];
  assign head_item = item_q[rd_ptr];

  // Pointers and fill level.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  // Storage.
  always_ff @(posedge clk) begin
    if (do_push) begin
      idx_q[wr_ptr]  <= push_idx;
      item_q[wr_ptr] <= push_item;
    end
  end

endmodule

// ===== hdl/dmpt_back.sv =====
// Back stage of the position table: slot memory, read-modify-write, counters and result.
// Also runs the clearing sweep after reset and after a clear transaction.
// Depends on dmpt_pkg.
`timescale 1ns / 1ps

module dmpt_back #(
  parameter int unsigned ENTRIES = dmpt_pkg::ENTRIES_DEFAULT
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              q_valid,
  input  logic [$clog2(ENTRIES)-1:0]        q_idx,
  input  dmpt_pkg::item_t                   q_item,
  output logic                              q_pop,
  output logic                              init_busy,
  output logic                              done,
  output dmpt_pkg::found_t                  found,
  output logic [dmpt_pkg::CNT_W-1:0]        searches,
  output logic [dmpt_pkg::CNT_W-1:0]        hits,
  output logic [dmpt_pkg::CNT_W-1:0]        collisions,
  output logic [dmpt_pkg::USED_W-1:0]       used_slots
);

  localparam int unsigned IDX_W = $clog2(ENTRIES);

  typedef enum logic [2:0] {
    S_IDLE  = 3'b001,
    S_EXEC  = 3'b010,
    S_CLEAR = 3'b100
  } state_t;

  state_t             state;
  logic               init;
  logic [IDX_W-1:0]   ptr;
  logic [IDX_W-1:0]   cur_idx;
  dmpt_pkg::item_t    cur;

  dmpt_pkg::entry_t   mem [ENTRIES];
  dmpt_pkg::entry_t   rd_data;
  logic               mem_we;
  logic [IDX_W-1:0]   mem_wa;
  dmpt_pkg::entry_t   mem_wd;

  logic               occupied;
  logic               key_eq;

  assign q_pop     = (state == S_IDLE) && q_valid;
  assign init_busy = init;
  assign occupied  = (rd_data.node_type != 2'd0);
  assign key_eq    = (rd_data.key == cur.key);

  // Memory write port: the sweep writes empty slots, a store writes the new entry.
  always_comb begin
    mem_we = 1'b0;
    mem_wa = cur_idx;
    mem_wd = '0;
    unique case (state)
      S_CLEAR: begin
        mem_we = 1'b1;
        mem_wa = ptr;
      end
      S_EXEC: begin
        if (cur.func == dmpt_pkg::FUNC_STORE) begin
          mem_we = 1'b1;
          mem_wd.node_type    = cur.node_type;
          mem_wd.key          = cur.key;
          mem_wd.score        = cur.score;
          mem_wd.search_depth = cur.search_depth;
          mem_wd.best_move    = cur.best_move;
        end
      end
      S_IDLE: begin
        mem_we = 1'b0;
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  // Slot memory with registered read data.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    if (q_pop) begin
      rd_data <= mem[q_idx];
    end
  end

  // Transaction latch.
  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur     <= q_item;
      cur_idx <= q_idx;
    end
  end

  // Sequencer, counters and result strobe.
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_CLEAR;
      init       <= 1'b1;
      ptr        <= '0;
      done       <= 1'b0;
      searches   <= '0;
      hits       <= '0;
      collisions <= '0;
      used_slots <= '0;
    end else begin
      done <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (q_valid) begin
            state <= S_EXEC;
          end
        end
        S_EXEC: begin
          done  <= 1'b1;
          state <= S_IDLE;
          if (cur.func == dmpt_pkg::FUNC_LOOKUP) begin
            if (searches != dmpt_pkg::CNT_MAX) begin
              searches <= searches + 1'b1;
            end
            if (occupied && key_eq && (hits != dmpt_pkg::CNT_MAX)) begin
              hits <= hits + 1'b1;
            end
          end else if (cur.func == dmpt_pkg::FUNC_STORE) begin
            if (!occupied) begin
              if (used_slots != dmpt_pkg::USED_MAX) begin
                used_slots <= used_slots + 1'b1;
              end
            end else if (!key_eq && (collisions != dmpt_pkg::CNT_MAX)) begin
              collisions <= collisions + 1'b1;
            end
          end else if (cur.func == dmpt_pkg::FUNC_CLEAR) begin
            searches   <= '0;
            hits       <= '0;
            collisions <= '0;
            used_slots <= '0;
            ptr        <= '0;
            state      <= S_CLEAR;
          end
        end
        S_CLEAR: begin
          ptr <= ptr + 1'b1;
          if (ptr == IDX_W'(ENTRIES - 1)) begin
            state <= S_IDLE;
            init  <= 1'b0;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Found fields: stored entry on a lookup hit, zero otherwise.
  always_ff @(posedge clk) begin
    if (state == S_EXEC) begin
      if ((cur.func == dmpt_pkg::FUNC_LOOKUP) && occupied && key_eq) begin
        found.hit         <= 1'b1;
        found.found_type  <= rd_data.node_type;
        found.found_score <= rd_data.score;
        found.found_depth <= rd_data.search_depth;
        found.found_move  <= rd_data.best_move;
      end else begin
        found <= '0;
      end
    end
  end

endmodule

// ===== hdl/direct_mapped_position_table.sv =====
// Top level of the direct-mapped position table.
// Connects the index front, the decoupling queue and the memory back.
// Depends on dmpt_pkg, dmpt_front, dmpt_queue and dmpt_back.
`timescale 1ns / 1ps

// Usage:
// A transaction (func, key and the entry fields) is accepted at a rising edge where start
// is high and busy is low. func selects lookup, store or clear; code 3 changes nothing.
// Every transaction gives exactly one result: done is high for one cycle and the result
// ports hold the found fields and the four counters after the operation during that cycle.
// The receiver cannot stall; results are never held back.
// A transaction passes the front stage, waits in the queue while the back is busy, and is
// read from the slot memory and executed in the back before done is raised. With a depth
// that is not a power of two the front first works out the remainder of the key. The front
// takes a new transaction once it has handed the last one to the queue; the back reads and
// then writes the slot memory in separate states for each transaction.
// A clear adds a sweep over all ENTRIES slots in the back; later transactions are queued and
// wait for it.
// Reset: rst is synchronous and active high. After reset the back sweeps all ENTRIES
// slots to empty; busy stays high for the whole sweep and no transaction is taken.
module direct_mapped_position_table #(
  parameter int unsigned ENTRIES = dmpt_pkg::ENTRIES_DEFAULT
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  output logic                              busy,
  input  logic [1:0]                        func,
  input  logic [dmpt_pkg::KEY_W-1:0]        key,
  input  logic [1:0]                        node_type,
  input  logic signed [15:0]                score,
  input  logic [7:0]                        search_depth,
  input  logic [15:0]                       best_move,
  output logic                              done,
  output logic                              hit,
  output logic [1:0]                        found_type,
  output logic signed [15:0]                found_score,
  output logic [7:0]                        found_depth,
  output logic [15:0]                       found_move,
  output logic [dmpt_pkg::CNT_W-1:0]        search_count,
  output logic [dmpt_pkg::CNT_W-1:0]        hit_count,
  output logic [dmpt_pkg::CNT_W-1:0]        collision_count,
  output logic [dmpt_pkg::USED_W-1:0]       used_count
);

  localparam int unsigned IDX_W = $clog2(ENTRIES);

  dmpt_pkg::item_t   in_item;
  logic              front_busy;
  logic              init_busy;
  logic              q_full;
  logic              q_push;
  logic [IDX_W-1:0]  f_idx;
  dmpt_pkg::item_t   f_item;
  logic              q_valid;
  logic              q_pop;
  logic [IDX_W-1:0]  h_idx;
  dmpt_pkg::item_t   h_item;
  dmpt_pkg::found_t  found;

  // Pack the input ports into one transaction.
  always_comb begin
    in_item.func         = func;
    in_item.key          = key;
    in_item.node_type    = node_type;
    in_item.score        = score;
    in_item.search_depth = search_depth;
    in_item.best_move    = best_move;
  end

  assign busy = front_busy || init_busy;

  dmpt_front #(
    .ENTRIES (ENTRIES)
  ) u_front (
    .clk     (clk),
    .rst     (rst),
    .start   (start && !init_busy),
    .in_item (in_item),
    .busy    (front_busy),
    .q_full  (q_full),
    .q_push  (q_push),
    .q_idx   (f_idx),
    .q_item  (f_item)
  );

  dmpt_queue #(
    .IDX_W (IDX_W)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_idx  (f_idx),
    .push_item (f_item),
    .full      (q_full),
    .pop       (q_pop),
    .valid     (q_valid),
    .head_idx  (h_idx),
    .head_item (h_item)
  );

  dmpt_back #(
    .ENTRIES (ENTRIES)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .q_valid    (q_valid),
    .q_idx      (h_idx),
    .q_item     (h_item),
    .q_pop      (q_pop),
    .init_busy  (init_busy),
    .done       (done),
    .found      (found),
    .searches   (search_count),
    .hits       (hit_count),
    .collisions (collision_count),
    .used_slots (used_count)
  );

  // Unpack the found fields onto the result ports.
  assign hit         = found.hit;
  assign found_type  = found.found_type;
  assign found_score = found.found_score;
  assign found_depth = found.found_depth;
  assign found_move  = found.found_move;

endmodule
